@@ rtl/mdd_pkg.sv @@
// Package for the marker-delimited deframer: field widths, marker characters,
// per-connection state and result descriptor types. No dependencies.
`default_nettype none
package mdd_pkg;

	localparam int CONNECTIONS_DEF = 16;
	localparam int CONN_W          = 4;
	localparam int BYTE_W          = 8;
	localparam int CNT_W           = 3;
	localparam int START_LEN       = 4;
	localparam int END_LEN         = 5;
	localparam int CONN_SPAN       = 1 << CONN_W;

	localparam logic [BYTE_W-1:0] CH_LT = 8'h3C;  // '<'

	typedef struct packed {
		logic             in_payload;
		logic [CNT_W-1:0] match_count;
	} conn_st_t;

	// one input word's worth of results: held end-marker prefix, then optional tail
	typedef struct packed {
		logic [CONN_W-1:0] conn;
		logic [CNT_W-1:0]  pre;
		logic              tail;
		logic              is_end;
		logic [BYTE_W-1:0] data;
	} res_desc_t;

	function automatic logic [BYTE_W-1:0] start_char(input logic [CNT_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			3'd0:    c = 8'h3C;  // '<'
			3'd1:    c = 8'h48;  // 'H'
			3'd2:    c = 8'h58;  // 'X'
			3'd3:    c = 8'h3E;  // '>'
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] end_char(input logic [CNT_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			3'd0:    c = 8'h3C;  // '<'
			3'd1:    c = 8'h45;  // 'E'
			3'd2:    c = 8'h4E;  // 'N'
			3'd3:    c = 8'h44;  // 'D'
			3'd4:    c = 8'h3E;  // '>'
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/mdd_state_mem.sv @@
// Per-connection state memory: synchronous RAM with registered read data,
// plus a written-since-reset bit per entry. Depends on mdd_pkg.
`default_nettype none
module mdd_state_mem #(
	parameter int DEPTH = mdd_pkg::CONNECTIONS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output mdd_pkg::conn_st_t     rd_data,
	input  wire logic [AW-1:0]    lk_addr,
	output logic                  lk_vld,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire mdd_pkg::conn_st_t wr_data
);

	mdd_pkg::conn_st_t mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	// unwritten entries read as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (wr_en)
			vld_q[wr_addr] <= 1'b1;
	end

	assign lk_vld = vld_q[lk_addr];

endmodule
`default_nettype wire

@@ rtl/mdd_out_seq.sv @@
// Output register and result sequencer: expands one descriptor into
// the held marker prefix bytes and the tail result. Depends on mdd_pkg.
`default_nettype none
module mdd_out_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        ld_valid,
	output logic                             ld_ready,
	input  wire mdd_pkg::res_desc_t          ld_desc,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mdd_pkg::CONN_W-1:0]       out_conn,
	output logic [mdd_pkg::BYTE_W-1:0]       out_byte,
	output logic                             byte_valid,
	output logic                             packet_end,
	output logic                             run_last
);

	logic                           vld_q;
	mdd_pkg::res_desc_t             desc_q;
	logic [mdd_pkg::CNT_W-1:0]      idx_q;
	logic                           in_pre;
	logic [mdd_pkg::CNT_W-1:0]      idx_nx;

	assign in_pre = (idx_q != desc_q.pre);
	assign idx_nx = idx_q + 1'b1;

	always_comb begin
		out_valid  = vld_q;
		out_conn   = desc_q.conn;
		run_last   = in_pre ? ((idx_nx == desc_q.pre) && !desc_q.tail) : 1'b1;
		if (in_pre) begin
			out_byte   = mdd_pkg::end_char(idx_q);
			byte_valid = 1'b1;
			packet_end = 1'b0;
		end else if (desc_q.is_end) begin
			out_byte   = '0;
			byte_valid = 1'b0;
			packet_end = 1'b1;
		end else begin
			out_byte   = desc_q.data;
			byte_valid = 1'b1;
			packet_end = 1'b0;
		end
	end

	assign ld_ready = !vld_q || (out_ready && run_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (ld_valid && ld_ready) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (vld_q && out_ready) begin
			if (run_last)
				vld_q <= 1'b0;
			else
				idx_q <= idx_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready)
			desc_q <= ld_desc;
	end

	assert property (@(posedge clk) disable iff (!arst_n) vld_q |-> (idx_q <= desc_q.pre))
		else $error("prefix index past held prefix");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !out_ready |=> vld_q && $stable(idx_q))
		else $error("result sequence advanced while stalled");

endmodule
`default_nettype wire

@@ rtl/marker_delimited_deframer.sv @@
// Marker-delimited deframer top level: read-modify-write of per-connection
// state held in mdd_state_mem, results expanded by mdd_out_seq.
// Depends on mdd_pkg, mdd_state_mem, mdd_out_seq.
//
// Input channel (in_valid/in_ready): one word per item, either a data byte of
// connection conn_id (kind = 0) or a close event for it (kind = 1).
// Output channel (out_valid/out_ready): payload bytes, end-of-packet marks;
// run_last flags the last result of an input word. Hunting bytes, marker
// completions of "<HX>", closes and conn_id >= CONNECTIONS give no result.
// The state RAM is read at accept and updated when the word leaves stage 1;
// the word is held in stage 1, its first result then in the output register.
// Throughput: one word per cycle while out_ready is high and each word gives
// at most one result. A word that flushes a broken "<END>" prefix gives up to
// five results, one per cycle while out_ready is high; the next word that has
// results waits in the update stage until the last of them leaves.
// Back-to-back words on the same connection are served by forwarding the
// written state around the RAM.
// Reset clears all connections to hunting at once (per-entry valid bits).
// When out_ready is low, one word waits in the output register, one more that
// has results in the update stage, then in_ready drops.
`default_nettype none
module marker_delimited_deframer #(
	parameter int CONNECTIONS = mdd_pkg::CONNECTIONS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        kind,
	input  wire logic [mdd_pkg::CONN_W-1:0]  conn_id,
	input  wire logic [mdd_pkg::BYTE_W-1:0]  data_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mdd_pkg::CONN_W-1:0]       out_conn,
	output logic [mdd_pkg::BYTE_W-1:0]       out_byte,
	output logic                             byte_valid,
	output logic                             packet_end,
	output logic                             run_last
);

	// only ids that fit conn_id can ever be addressed
	localparam int DEPTH = (CONNECTIONS < mdd_pkg::CONN_SPAN) ? CONNECTIONS
	                                                          : mdd_pkg::CONN_SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                          in_fire;
	logic                          valid_s1;
	logic                          kind_s1;
	logic [mdd_pkg::CONN_W-1:0]    conn_s1;
	logic [mdd_pkg::BYTE_W-1:0]    byte_s1;
	logic                          fwd_s1;
	mdd_pkg::conn_st_t             fwd_st_q;

	mdd_pkg::conn_st_t             rd_st;
	logic                          lk_vld;
	mdd_pkg::conn_st_t             cur_st;
	mdd_pkg::conn_st_t             new_st;
	mdd_pkg::res_desc_t            desc;
	logic                          has_res;
	logic                          in_range_s1;
	logic                          s1_fire;
	logic                          wr_en;
	logic                          seq_ready;
	logic [mdd_pkg::CNT_W-1:0]     c;

	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;
	assign in_range_s1 = (32'(conn_s1) < CONNECTIONS);

	mdd_state_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (conn_id[AW-1:0]),
		.rd_data (rd_st),
		.lk_addr (conn_s1[AW-1:0]),
		.lk_vld  (lk_vld),
		.wr_en   (wr_en),
		.wr_addr (conn_s1[AW-1:0]),
		.wr_data (new_st)
	);

	// state update for the word in stage 1
	always_comb begin
		cur_st  = fwd_s1 ? fwd_st_q : (lk_vld ? rd_st : '0);
		new_st  = cur_st;
		has_res = 1'b0;
		c       = cur_st.match_count;
		desc.conn   = conn_s1;
		desc.pre    = '0;
		desc.tail   = 1'b0;
		desc.is_end = 1'b0;
		desc.data   = byte_s1;
		if (kind_s1) begin
			new_st = '0;
		end else if (!cur_st.in_payload) begin
			if (c >= 3'(mdd_pkg::START_LEN))
				c = '0;
			if (byte_s1 == mdd_pkg::start_char(c)) begin
				c = c + 1'b1;
				if (c == 3'(mdd_pkg::START_LEN)) begin
					new_st.in_payload = 1'b1;
					c = '0;
				end
			end else begin
				c = (byte_s1 == mdd_pkg::CH_LT) ? 3'd1 : 3'd0;
			end
			new_st.match_count = c;
		end else begin
			if (c >= 3'(mdd_pkg::END_LEN))
				c = '0;
			if (byte_s1 == mdd_pkg::end_char(c)) begin
				c = c + 1'b1;
				if (c == 3'(mdd_pkg::END_LEN)) begin
					new_st.in_payload = 1'b0;
					c           = '0;
					has_res     = 1'b1;
					desc.tail   = 1'b1;
					desc.is_end = 1'b1;
				end
			end else begin
				// broken match: flush held prefix, then the byte unless it restarts
				desc.pre  = c;
				desc.tail = (byte_s1 != mdd_pkg::CH_LT);
				has_res   = desc.tail || (c != '0);
				c         = (byte_s1 == mdd_pkg::CH_LT) ? 3'd1 : 3'd0;
			end
			new_st.match_count = c;
		end
		if (!in_range_s1)
			has_res = 1'b0;
	end

	assign s1_fire = valid_s1 && (!has_res || seq_ready);
	assign wr_en   = s1_fire && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= wr_en && (conn_s1 == conn_id);
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= kind;
			conn_s1 <= conn_id;
			byte_s1 <= data_byte;
		end
		if (wr_en)
			fwd_st_q <= new_st;
	end

	mdd_out_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_valid   (valid_s1 && has_res),
		.ld_ready   (seq_ready),
		.ld_desc    (desc),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_conn   (out_conn),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.packet_end (packet_end),
		.run_last   (run_last)
	);

	assert property (@(posedge clk) disable iff (!arst_n) fwd_s1 |-> valid_s1)
		else $error("forward flag without a word in stage 1");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (new_st.in_payload ? (new_st.match_count <= 3'd4)
		                             : (new_st.match_count <= 3'd3)))
		else $error("match count out of range for phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(conn_s1) && $stable(byte_s1))
		else $error("stage 1 word lost while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && kind_s1 |-> (new_st == '0))
		else $error("close did not clear connection state");

endmodule
`default_nettype wire
